FILE: rtl/interval_diff_encoder_unit_defines.svh
// assertion macros for the interval diff encoder
`ifndef INTERVAL_DIFF_ENCODER_UNIT_DEFINES_SVH
`define INTERVAL_DIFF_ENCODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define IDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define IDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IDE_ASSERT(lbl, prop, msg)
`define IDE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/ide_pkg.sv
`default_nettype none

package ide_pkg;

  localparam int IDE_INDEX_BITS   = 24;
  localparam int IDE_GROUP_WORDS  = 4;
  localparam int IDE_WORD_W       = 64;
  localparam int IDE_ADDR_W       = 24;
  localparam int IDE_WIN_W        = 16;
  localparam int IDE_START_W      = 24;
  localparam int IDE_TRAIL_W      = 17;
  localparam int IDE_CFG_IDX_W    = 2;
  localparam int IDE_CFG_DATA_W   = 32;
  localparam int IDE_WINDOW_RESET = 16;

  typedef enum logic [2:0] {
    TGT_DIFF      = 3'd0,
    TGT_HDR_START = 3'd1,
    TGT_HDR_END   = 3'd2,
    TGT_OLD       = 3'd3,
    TGT_DONE      = 3'd4
  } ide_target_e;

  typedef enum logic [IDE_CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE = 2'd0,
    CFG_START_INDEX = 2'd1
  } ide_cfg_e;

  // result phases in emission order
  typedef enum logic [2:0] {
    PH_OLD_A = 3'd0,
    PH_DIFF  = 3'd1,
    PH_OLD_B = 3'd2,
    PH_START = 3'd3,
    PH_END   = 3'd4,
    PH_DONE  = 3'd5
  } ide_phase_e;

  localparam int IDE_PH_NUM = 6;

  typedef struct packed {
    logic [IDE_WORD_W-1:0] new_word0;
    logic [IDE_WORD_W-1:0] new_word1;
    logic [IDE_WORD_W-1:0] new_word2;
    logic [IDE_WORD_W-1:0] new_word3;
    logic [IDE_WORD_W-1:0] old_word0;
    logic [IDE_WORD_W-1:0] old_word1;
    logic [IDE_WORD_W-1:0] old_word2;
    logic [IDE_WORD_W-1:0] old_word3;
    logic                  final_group;
  } ide_in_t;

  typedef struct packed {
    ide_target_e           target;
    logic [IDE_ADDR_W-1:0] address;
    logic [IDE_WORD_W-1:0] payload;
    logic                  last_of_item;
  } ide_out_t;

endpackage

`default_nettype wire

FILE: rtl/interval_diff_encoder_unit.sv
// interval diff encoder: one group of four word pairs in, up to eleven addressed writes out
// path: an accepted group passes the input register, then the plan register, then the output register
// throughput: one result per cycle while the output is not stalled, so a group with n results (1 to 11)
//   holds the plan register until its last result is emitted; a group with none leaves the input register without it
// reset: async active low, clears run state, loads window_size 16 and start_index 0
`default_nettype none
`include "interval_diff_encoder_unit_defines.svh"

module interval_diff_encoder_unit
  import ide_pkg::*;
#(
  parameter int INDEX_BITS = IDE_INDEX_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration writes
  input  wire logic                      cfg_valid_i,
  output      logic                      cfg_ready_o,
  input  wire logic [IDE_CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [IDE_CFG_DATA_W-1:0] cfg_data_i,
  // group items
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire ide_in_t                   in_data_i,
  // result items
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      ide_out_t                  out_data_o
);

  localparam int IB = INDEX_BITS;

  // configuration registers
  logic [IDE_WIN_W-1:0]   window_size_q;
  logic [IDE_START_W-1:0] start_index_q;

  // run state
  logic                   copy_mode_q, copy_mode_d;
  logic [IB-1:0]          group_index_q, group_index_d;
  logic [IB-1:0]          write_pointer_q, write_pointer_d;
  logic [IB-1:0]          header_pointer_q, header_pointer_d;
  logic [IDE_TRAIL_W-1:0] trailing_equal_q, trailing_equal_d;

  // input register
  logic    a_valid_q;
  ide_in_t a_data_q;

  // plan register: what the group emits, walked one result per cycle while the output is not stalled
  logic                  b_valid_q;
  logic [IDE_PH_NUM-1:0] b_en_q, en_d;
  logic [IDE_WORD_W-1:0] b_word_q [IDE_GROUP_WORDS];
  logic [IB-1:0]         b_g_q;
  logic [IB-1:0]         b_diff_base_q, diff_base_d;
  logic [1:0]            b_diff_first_q, diff_first_d;
  logic [IB-1:0]         b_hp_q, hp_plan_d;
  logic [IB-1:0]         b_start_val_q, start_val_d;
  logic [IB-1:0]         b_end_val_q, end_val_d;
  logic [IB-1:0]         b_done_val_q, done_val_d;

  // result sequencer
  ide_phase_e ph_q, ph_d;
  logic [1:0] sub_q, sub_d;

  // output register
  logic     out_valid_q;
  ide_out_t out_data_q;

  // handshake glue
  logic step_adv, phase_end, nxt_found, last_step, b_done, plan_avail, a_move, has_res;
  ide_phase_e nxt_ph, first_ph;
  ide_out_t   emit;

  assign cfg_ready_o = 1'b1;   // the user must write only while idle; the block does not enforce this
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign step_adv   = b_valid_q && (!out_valid_q || out_ready_i);
  assign last_step  = phase_end && !nxt_found;
  assign b_done     = step_adv && last_step;
  assign plan_avail = !b_valid_q || b_done;
  assign a_move     = a_valid_q && plan_avail;
  assign in_ready_o = !a_valid_q || a_move;
  assign has_res    = |en_d;

  // ---------------------------------------------------------------------------
  // group evaluation: compare words, decide the run action, plan the results
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [IDE_WORD_W-1:0]  nw [IDE_GROUP_WORDS];
    logic [IDE_WORD_W-1:0]  ow [IDE_GROUP_WORDS];
    logic [IDE_GROUP_WORDS-1:0] eq;
    logic                   any_diff;
    logic [1:0]             first;
    logic [2:0]             top;
    logic [IB-1:0]          g4;
    logic [IB-1:0]          wp_end;
    logic [IB-1:0]          tr_ib;
    logic [IDE_TRAIL_W-1:0] tr;
    logic                   close;
    logic                   fin;

    nw[0] = a_data_q.new_word0;
    nw[1] = a_data_q.new_word1;
    nw[2] = a_data_q.new_word2;
    nw[3] = a_data_q.new_word3;
    ow[0] = a_data_q.old_word0;
    ow[1] = a_data_q.old_word1;
    ow[2] = a_data_q.old_word2;
    ow[3] = a_data_q.old_word3;
    fin   = a_data_q.final_group;

    for (int z = 0; z < IDE_GROUP_WORDS; z++) begin
      eq[z] = (nw[z] == ow[z]);
    end
    any_diff = !(&eq);

    // lowest changed word
    first = 2'd0;
    for (int z = IDE_GROUP_WORDS - 1; z >= 0; z--) begin
      if (!eq[z]) begin
        first = 2'(z);
      end
    end

    // equal words counted down from the top of the group
    if (!eq[3])      top = 3'd0;
    else if (!eq[2]) top = 3'd1;
    else if (!eq[1]) top = 3'd2;
    else if (!eq[0]) top = 3'd3;
    else             top = 3'd4;

    g4     = IB'(group_index_q + IB'(IDE_GROUP_WORDS));
    wp_end = IB'(write_pointer_q + IB'(1) + IB'(3'd4 - {1'b0, first}));
    tr     = (&eq) ? IDE_TRAIL_W'(trailing_equal_q + IDE_TRAIL_W'(IDE_GROUP_WORDS))
                   : IDE_TRAIL_W'(top);
    tr_ib  = IB'(tr);
    close  = tr > IDE_TRAIL_W'(window_size_q);

    // defaults: state holds, nothing to emit
    copy_mode_d      = copy_mode_q;
    group_index_d    = group_index_q;
    write_pointer_d  = write_pointer_q;
    header_pointer_d = header_pointer_q;
    trailing_equal_d = trailing_equal_q;
    en_d             = '0;
    diff_base_d      = write_pointer_q;
    diff_first_d     = 2'd0;
    hp_plan_d        = header_pointer_q;
    start_val_d      = IB'(group_index_q + IB'(first));
    end_val_d        = g4;
    done_val_d       = write_pointer_q;

    if (!copy_mode_q) begin
      if (!any_diff) begin
        // unchanged group while scanning
        group_index_d = g4;
        if (fin) begin
          en_d[PH_DONE] = 1'b1;
        end
      end else begin
        // open a run: header word reserved at the current pointer
        en_d[PH_OLD_A] = 1'b1;
        en_d[PH_DIFF]  = 1'b1;
        en_d[PH_START] = 1'b1;
        hp_plan_d      = write_pointer_q;
        diff_base_d    = IB'(write_pointer_q + IB'(1));
        diff_first_d   = first;
        done_val_d     = wp_end;
        if (fin) begin
          en_d[PH_END]  = 1'b1;
          en_d[PH_DONE] = 1'b1;
        end else begin
          copy_mode_d      = 1'b1;
          group_index_d    = g4;
          header_pointer_d = write_pointer_q;
          write_pointer_d  = wp_end;
          trailing_equal_d = IDE_TRAIL_W'(top);
        end
      end
    end else begin
      // inside a run: whole group goes to the diff store
      en_d[PH_DIFF]  = 1'b1;
      en_d[PH_OLD_B] = !close;
      en_d[PH_END]   = close || fin;
      en_d[PH_DONE]  = fin;
      end_val_d      = IB'(g4 - tr_ib);
      if (close || fin) begin
        done_val_d = IB'(write_pointer_q + IB'(IDE_GROUP_WORDS) - tr_ib);
      end else begin
        done_val_d = IB'(write_pointer_q + IB'(IDE_GROUP_WORDS));
      end
      if (!fin) begin
        copy_mode_d      = !close;
        group_index_d    = g4;
        write_pointer_d  = done_val_d;
        trailing_equal_d = close ? '0 : tr;
      end
    end

    // buffer finished: rearm for the next one
    if (fin) begin
      copy_mode_d      = 1'b0;
      group_index_d    = IB'(start_index_q);
      write_pointer_d  = '0;
      header_pointer_d = '0;
      trailing_equal_d = '0;
    end
  end

  // first phase of a freshly loaded plan
  always_comb begin
    first_ph = PH_DONE;
    for (int i = IDE_PH_NUM - 1; i >= 0; i--) begin
      if (en_d[i]) begin
        first_ph = ide_phase_e'(3'(i));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    nxt_found = 1'b0;
    nxt_ph    = PH_DONE;
    for (int i = IDE_PH_NUM - 1; i >= 0; i--) begin
      if (b_en_q[i] && (i > int'(ph_q))) begin
        nxt_found = 1'b1;
        nxt_ph    = ide_phase_e'(3'(i));
      end
    end

    unique case (ph_q)
      PH_OLD_A, PH_DIFF, PH_OLD_B: phase_end = (sub_q == 2'd3);
      PH_START, PH_END, PH_DONE:   phase_end = 1'b1;
      default:                     phase_end = 1'b1;
    endcase

    ph_d  = ph_q;
    sub_d = sub_q;
    if (a_move && has_res) begin
      ph_d  = first_ph;
      sub_d = (first_ph == PH_DIFF) ? diff_first_d : 2'd0;
    end else if (step_adv) begin
      if (phase_end) begin
        ph_d  = nxt_ph;
        sub_d = (nxt_ph == PH_DIFF) ? b_diff_first_q : 2'd0;
      end else begin
        sub_d = 2'(sub_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_OLD_A;
      sub_q <= 2'd0;
    end else begin
      ph_q  <= ph_d;
      sub_q <= sub_d;
    end
  end

  // current result from the plan and the step
  always_comb begin
    logic [1:0] off;
    off          = 2'(sub_q - b_diff_first_q);
    emit         = '0;
    emit.payload = b_word_q[sub_q];
    unique case (ph_q)
      PH_OLD_A, PH_OLD_B: begin
        emit.target  = TGT_OLD;
        emit.address = IDE_ADDR_W'(IB'(b_g_q + IB'(sub_q)));
      end
      PH_DIFF: begin
        emit.target  = TGT_DIFF;
        emit.address = IDE_ADDR_W'(IB'(b_diff_base_q + IB'(off)));
      end
      PH_START: begin
        emit.target  = TGT_HDR_START;
        emit.address = IDE_ADDR_W'(b_hp_q);
        emit.payload = IDE_WORD_W'(b_start_val_q);
      end
      PH_END: begin
        emit.target  = TGT_HDR_END;
        emit.address = IDE_ADDR_W'(b_hp_q);
        emit.payload = IDE_WORD_W'(b_end_val_q);
      end
      PH_DONE: begin
        emit.target  = TGT_DONE;
        emit.address = '0;
        emit.payload = IDE_WORD_W'(b_done_val_q);
      end
      default: begin
        emit.target = TGT_DONE;
      end
    endcase
    emit.last_of_item = last_step;
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q    <= IDE_WIN_W'(IDE_WINDOW_RESET);
      start_index_q    <= '0;
      copy_mode_q      <= 1'b0;
      group_index_q    <= '0;
      write_pointer_q  <= '0;
      header_pointer_q <= '0;
      trailing_equal_q <= '0;
      a_valid_q        <= 1'b0;
      b_valid_q        <= 1'b0;
      b_en_q           <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end

      if (a_move) begin
        copy_mode_q      <= copy_mode_d;
        group_index_q    <= group_index_d;
        write_pointer_q  <= write_pointer_d;
        header_pointer_q <= header_pointer_d;
        trailing_equal_q <= trailing_equal_d;
        b_valid_q        <= has_res;
        b_en_q           <= en_d;
      end else if (b_done) begin
        b_valid_q <= 1'b0;
      end

      if (step_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // a start index write also reloads the group index
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_WINDOW_SIZE: window_size_q <= cfg_data_i[IDE_WIN_W-1:0];
          CFG_START_INDEX: begin
            start_index_q <= cfg_data_i[IDE_START_W-1:0];
            group_index_q <= IB'(cfg_data_i[IDE_START_W-1:0]);
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_data_q <= in_data_i;
    end
    if (a_move && has_res) begin
      b_word_q[0]    <= a_data_q.new_word0;
      b_word_q[1]    <= a_data_q.new_word1;
      b_word_q[2]    <= a_data_q.new_word2;
      b_word_q[3]    <= a_data_q.new_word3;
      b_g_q          <= group_index_q;
      b_diff_base_q  <= diff_base_d;
      b_diff_first_q <= diff_first_d;
      b_hp_q         <= hp_plan_d;
      b_start_val_q  <= start_val_d;
      b_end_val_q    <= end_val_d;
      b_done_val_q   <= done_val_d;
    end
    if (step_adv) begin
      out_data_q <= emit;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `IDE_ASSERT(a_plan_phase_on, b_valid_q |-> b_en_q[ph_q], "sequencer in a disabled phase")
  `IDE_ASSERT(a_diff_step, b_valid_q && ph_q == PH_DIFF |-> sub_q >= b_diff_first_q, "diff step low")
  `IDE_ASSERT(a_done_last, out_valid_o && out_data_o.target == TGT_DONE |-> out_data_o.last_of_item, "done not last")
  `IDE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result valid right after reset")

endmodule

`default_nettype wire
